/* hw/rtl/lkvt_pkg.sv */
// ----------------------------------------------------------------------------
// Linear key-value table package
// Shared sizes, field types, action and status codes, and sequencer states.
// ----------------------------------------------------------------------------
package lkvt_pkg;

    // Table capacity and the widths that follow from it.
    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Fixed field widths.
    localparam int ACTION_W      = 2;
    localparam int KEY_W         = 32;
    localparam int VALUE_W       = 32;
    localparam int ENTRY_COUNT_W = 5;
    localparam int ENTRY_W       = KEY_W + VALUE_W;

    typedef logic [ACTION_W-1:0]      action_t;
    typedef logic [KEY_W-1:0]         key_t;
    typedef logic signed [VALUE_W-1:0] value_t;
    typedef logic [ENTRY_COUNT_W-1:0] entry_count_t;
    typedef logic [IDX_W-1:0]         idx_t;
    typedef logic [CNT_W-1:0]         cnt_t;

    // Action codes; the fourth code is a no-operation that still reports found.
    localparam action_t ACT_LOOKUP = 2'd0;
    localparam action_t ACT_INSERT = 2'd1;
    localparam action_t ACT_DELETE = 2'd2;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_DONE   = 2'd0,
        STATUS_ABSENT = 2'd1,
        STATUS_DUP    = 2'd2,
        STATUS_FULL   = 2'd3
    } status_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_SHIFT,
        ST_FINISH
    } state_t;

endpackage

/* hw/rtl/lkvt_if.sv */
// ----------------------------------------------------------------------------
// Linear key-value table channels
// Valid/ready channels for requests, results and the miss value register.
// ----------------------------------------------------------------------------

// Request channel: one action on one key.
interface lkvt_req_if;
    import lkvt_pkg::*;

    logic    valid;
    logic    ready;
    action_t action;
    key_t    key;
    value_t  value;

    modport source (output valid, output action, output key, output value, input ready);
    modport sink   (input valid, input action, input key, input value, output ready);
endinterface

// Result channel: one result per request.
interface lkvt_rsp_if;
    import lkvt_pkg::*;

    logic         valid;
    logic         ready;
    value_t       read_value;
    logic         found;
    status_t      status;
    entry_count_t entry_count;

    modport source (output valid, output read_value, output found, output status,
                    output entry_count, input ready);
    modport sink   (input valid, input read_value, input found, input status,
                    input entry_count, output ready);
endinterface

// Configuration write channel for the miss value.
interface lkvt_cfg_if;
    import lkvt_pkg::*;

    logic   valid;
    logic   ready;
    value_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/linear_key_value_table_core.sv */
// ----------------------------------------------------------------------------
// Linear key-value table core
// Packed table of key-value pairs with lookup, insert and delete by key.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Carries
//  --------+-----------+------------------------------------------------
//  cfg     | in        | miss value written into the register
//  req     | in        | action, key, value
//  rsp     | out       | read_value, found, status, entry_count
//
// The search reads the stored slots in order, back to back on the single read
// port, and a finish step then loads the result into the output register.
// The search stops at the matching slot. A delete then moves each pair above
// that slot down by one, one pair per cycle through the same port. The
// sequencer returns to idle before the next request is accepted.
// Reset clears the pair count and the miss value; RAM contents stay as they are.
// The result sits in an output register; a stalled result holds the finish
// step, while the next request is still accepted during the stall.
// ----------------------------------------------------------------------------
module linear_key_value_table_core (
    input  logic       clk,
    input  logic       rst_n,
    lkvt_cfg_if.sink   cfg,
    lkvt_req_if.sink   req,
    lkvt_rsp_if.source rsp
);
    import lkvt_pkg::*;

    // Sequencer and request registers.
    state_t  state_reg, state_next;
    action_t action_reg, action_next;
    key_t    key_reg, key_next;
    value_t  value_reg, value_next;
    idx_t    ptr_reg, ptr_next;
    logic    hit_reg, hit_next;
    value_t  hit_value_reg, hit_value_next;
    cnt_t    count_reg, count_next;
    value_t  miss_value_reg;

    // Output register.
    logic         rsp_valid_reg, rsp_valid_next;
    value_t       read_value_reg, read_value_next;
    logic         found_reg, found_next;
    status_t      status_reg, status_next;
    entry_count_t entry_count_reg, entry_count_next;

    // RAM ports.
    logic               ram_wr_en;
    idx_t               ram_wr_addr;
    logic [ENTRY_W-1:0] ram_wr_data;
    logic               ram_rd_en;
    idx_t               ram_rd_addr;
    logic [ENTRY_W-1:0] ram_rd_data;

    // Decoded RAM read data and walk conditions.
    key_t   rd_key;
    value_t rd_value;
    logic   key_match;
    logic   last_slot;
    logic   out_free;
    logic   req_fire;
    logic   finish_fire;

    assign rd_key      = ram_rd_data[ENTRY_W-1:VALUE_W];
    assign rd_value    = ram_rd_data[VALUE_W-1:0];
    assign key_match   = (rd_key == key_reg);
    assign last_slot   = ((CNT_W'(ptr_reg) + CNT_W'(1)) == count_reg);
    assign out_free    = !rsp_valid_reg || rsp.ready;
    assign req_fire    = req.valid && req.ready;
    assign finish_fire = (state_reg == ST_FINISH) && out_free;

    // Key and value share one entry of the RAM.
    lkvt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Configuration register.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            miss_value_reg <= '0;
        end
        else if (cfg.valid)
        begin
            miss_value_reg <= cfg.data;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = (count_reg == '0) ? ST_FINISH : ST_SEARCH;
                end
            end
            ST_SEARCH:
            begin
                if (key_match)
                begin
                    state_next = (action_reg == ACT_DELETE && !last_slot) ? ST_SHIFT
                                                                          : ST_FINISH;
                end
                else if (last_slot)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SHIFT:
            begin
                if (last_slot)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath next values: request capture, walk pointer, hit and result.
    always_comb
    begin
        action_next      = action_reg;
        key_next         = key_reg;
        value_next       = value_reg;
        ptr_next         = ptr_reg;
        hit_next         = hit_reg;
        hit_value_next   = hit_value_reg;
        count_next       = count_reg;
        read_value_next  = read_value_reg;
        found_next       = found_reg;
        status_next      = status_reg;
        entry_count_next = entry_count_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp.ready;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    action_next = req.action;
                    key_next    = req.key;
                    value_next  = req.value;
                    ptr_next    = '0;
                    hit_next    = 1'b0;
                end
            end
            ST_SEARCH:
            begin
                if (key_match)
                begin
                    hit_next       = 1'b1;
                    hit_value_next = rd_value;
                end
                if (!last_slot)
                begin
                    ptr_next = ptr_reg + idx_t'(1);
                end
            end
            ST_SHIFT:
            begin
                if (!last_slot)
                begin
                    ptr_next = ptr_reg + idx_t'(1);
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    read_value_next = '0;
                    found_next      = hit_reg;
                    status_next     = STATUS_DONE;
                    case (action_reg)
                        ACT_LOOKUP:
                        begin
                            if (hit_reg)
                            begin
                                read_value_next = hit_value_reg;
                            end
                            else
                            begin
                                read_value_next = miss_value_reg;
                                status_next     = STATUS_ABSENT;
                            end
                        end
                        ACT_INSERT:
                        begin
                            if (count_reg == CNT_W'(CAPACITY))
                            begin
                                status_next = STATUS_FULL;
                            end
                            else if (hit_reg)
                            begin
                                status_next = STATUS_DUP;
                            end
                            else
                            begin
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        ACT_DELETE:
                        begin
                            if (hit_reg)
                            begin
                                count_next = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                status_next = STATUS_ABSENT;
                            end
                        end
                        default:
                        begin
                            status_next = STATUS_DONE;
                        end
                    endcase
                    entry_count_next = ENTRY_COUNT_W'(count_next);
                    rsp_valid_next   = 1'b1;
                end
            end
            default:
            begin
                ptr_next = '0;
            end
        endcase
    end

    // Outputs: handshake and RAM control.
    always_comb
    begin
        req.ready   = (state_reg == ST_IDLE);
        ram_rd_en   = 1'b0;
        ram_rd_addr = ptr_reg + idx_t'(1);
        ram_wr_en   = 1'b0;
        ram_wr_addr = ptr_reg - idx_t'(1);
        ram_wr_data = ram_rd_data;
        case (state_reg)
            ST_IDLE:
            begin
                // First slot is read as the request comes in.
                ram_rd_en   = req_fire && (count_reg != '0);
                ram_rd_addr = '0;
            end
            ST_SEARCH:
            begin
                ram_rd_en = !last_slot;
            end
            ST_SHIFT:
            begin
                // Move the slot just read one place down, read the next one.
                ram_rd_en = !last_slot;
                ram_wr_en = 1'b1;
            end
            ST_FINISH:
            begin
                // Append a new pair behind the last stored one.
                ram_wr_en   = out_free && (action_reg == ACT_INSERT) && !hit_reg
                              && (count_reg != CNT_W'(CAPACITY));
                ram_wr_addr = idx_t'(count_reg);
                ram_wr_data = {key_reg, value_reg};
            end
            default:
            begin
                ram_rd_en = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        action_reg      <= action_next;
        key_reg         <= key_next;
        value_reg       <= value_next;
        ptr_reg         <= ptr_next;
        hit_reg         <= hit_next;
        hit_value_reg   <= hit_value_next;
        read_value_reg  <= read_value_next;
        found_reg       <= found_next;
        status_reg      <= status_next;
        entry_count_reg <= entry_count_next;
    end

    // Result port.
    assign rsp.valid       = rsp_valid_reg;
    assign rsp.read_value  = read_value_reg;
    assign rsp.found       = found_reg;
    assign rsp.status      = status_reg;
    assign rsp.entry_count = entry_count_reg;

    // The pair count never exceeds the capacity.
    a_count_bound: assert property (
        @(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY)
    ) else $error("pair count above capacity");

    // The count only moves when a result is loaded.
    a_count_at_finish: assert property (
        @(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> $past(finish_fire)
    ) else $error("pair count changed outside the finish step");

    // Writes never go above the first free slot.
    a_write_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        ram_wr_en |-> (CNT_W'(ram_wr_addr) <= count_reg)
    ) else $error("RAM write beyond the stored pairs");

    // The shift walk never reads and writes the same slot in one cycle.
    a_no_rw_collision: assert property (
        @(posedge clk) disable iff (!rst_n)
        (ram_rd_en && ram_wr_en) |-> (ram_rd_addr != ram_wr_addr)
    ) else $error("RAM read and write to the same slot");

endmodule

/* hw/rtl/lkvt_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module lkvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
